### sv/cpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Contiguous page allocator package
// Sizes, flag and status codes, and the structs shared by the allocator's
// modules.
// ----------------------------------------------------------------------------
package cpa_pkg;

   localparam int TABLE_PAGES = 1024;
   localparam int PAGE_BYTES  = 256;

   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int IDX_W      = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
   localparam int CNT_W      = $clog2(TABLE_PAGES + 1);

   localparam int ADDR_W   = 32;
   localparam int LEN_W    = 11;
   localparam int STATUS_W = 2;
   localparam int FLAG_W   = 2;
   localparam int CSR_W    = 32;

   localparam logic [LEN_W-1:0] PAGES_RESET = 11'd1024;

   localparam logic [FLAG_W-1:0] FLAG_TAKEN = 2'b01;
   localparam logic [FLAG_W-1:0] FLAG_LAST  = 2'b10;
   localparam logic [FLAG_W-1:0] FLAG_FREE  = 2'b00;

   localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   localparam logic CSR_HEAP_BASE    = 1'b0;
   localparam logic CSR_PAGES_IN_USE = 1'b1;

   typedef enum logic [2:0] {
      STATE_CLEAR,
      STATE_IDLE,
      STATE_SCAN,
      STATE_MARK,
      STATE_WALK
   } state_type;

   typedef struct packed {
      logic              we;
      logic [IDX_W-1:0]  waddr;
      logic [FLAG_W-1:0] wdata;
      logic [IDX_W-1:0]  raddr;
   } mem_req_type;

   typedef struct packed {
      logic                valid;
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   address;
   } rsp_type;

endpackage
`default_nettype wire

### sv/cpa_page_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Page flag memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module cpa_page_ram
   import cpa_pkg::*;
(
   input  wire                      clock,
   input  mem_req_type              mem_req,
   output logic [FLAG_W-1:0]        rd_data
);

   logic [FLAG_W-1:0] mem [TABLE_PAGES];
   logic [FLAG_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[mem_req.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### sv/cpa_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Allocator engine
// Sequencer for the reset clearing pass, the first-fit scan, the marking of
// a found run and the freeing walk, all through the page flag memory.
// ----------------------------------------------------------------------------
module cpa_engine
   import cpa_pkg::*;
(
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      start,
   output logic                     busy,
   input  wire                      req_action,
   input  wire  [LEN_W-1:0]         req_run_length,
   input  wire  [ADDR_W-1:0]        req_block_address,
   input  wire  [ADDR_W-1:0]        heap_base,
   input  wire  [CNT_W-1:0]         page_count,
   output mem_req_type              mem_req,
   input  wire  [FLAG_W-1:0]        rd_data,
   output rsp_type                  rsp
);

   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    eidx_ff, eidx_in;
   logic [CNT_W-1:0]    run_ff, run_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [IDX_W-1:0]    start_ff, start_in;
   logic [IDX_W-1:0]    end_ff, end_in;
   logic [IDX_W-1:0]    wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]    page_ff, page_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]   rsp_address_ff, rsp_address_in;

   logic                accept;
   logic                len_bad;
   logic [ADDR_W-1:0]   offset;
   logic [ADDR_W-1:0]   free_page;
   logic                free_bad;
   logic                taken;
   logic                last;
   logic [CNT_W-1:0]    run_inc;
   logic                found;
   logic                scan_end;
   logic                mark_end;
   logic                walk_end;
   logic                clear_end;
   logic [31:0]         run_start;

   // Request decode and per-cycle conditions.
   always_comb begin
      accept    = start && (state_ff == STATE_IDLE);
      len_bad   = (req_run_length == '0)
                  || (32'(req_run_length) > 32'(page_count));
      offset    = req_block_address - heap_base;
      free_page = offset >> PAGE_SHIFT;
      free_bad  = (req_block_address == '0) || (req_block_address < heap_base)
                  || (free_page >= 32'(page_count));
      taken     = (rd_data & FLAG_TAKEN) != '0;
      last      = (rd_data & FLAG_LAST) != '0;
      run_inc   = run_ff + CNT_W'(1);
      found     = !taken && (32'(run_inc) == 32'(len_ff));
      scan_end  = (32'(eidx_ff) + 32'd1) == 32'(page_count);
      mark_end  = wr_idx_ff == end_ff;
      walk_end  = !taken || last || ((32'(page_ff) + 32'd1) == 32'(page_count));
      clear_end = wr_idx_ff == IDX_W'(TABLE_PAGES - 1);
      run_start = 32'(eidx_ff) + 32'd1 - 32'(len_ff);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         STATE_CLEAR: begin
            if (clear_end) begin
               state_in = STATE_IDLE;
            end
         end
         STATE_IDLE: begin
            if (accept) begin
               if (req_action == ACT_ALLOC) begin
                  if (!len_bad) begin
                     state_in = STATE_SCAN;
                  end
               end else if (!free_bad) begin
                  state_in = STATE_WALK;
               end
            end
         end
         STATE_SCAN: begin
            if (found) begin
               state_in = STATE_MARK;
            end else if (scan_end) begin
               state_in = STATE_IDLE;
            end
         end
         STATE_MARK: begin
            if (mark_end) begin
               state_in = STATE_IDLE;
            end
         end
         STATE_WALK: begin
            if (walk_end) begin
               state_in = STATE_IDLE;
            end
         end
         default: begin
            state_in = STATE_CLEAR;
         end
      endcase
   end

   // Memory accesses, datapath updates and the result.
   always_comb begin
      eidx_in        = eidx_ff;
      run_in         = run_ff;
      len_in         = len_ff;
      start_in       = start_ff;
      end_in         = end_ff;
      wr_idx_in      = wr_idx_ff;
      page_in        = page_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_address_in = rsp_address_ff;
      mem_req.we     = 1'b0;
      mem_req.waddr  = wr_idx_ff;
      mem_req.wdata  = FLAG_FREE;
      mem_req.raddr  = eidx_ff + IDX_W'(1);
      unique case (state_ff)
         STATE_CLEAR: begin
            mem_req.we = 1'b1;
            wr_idx_in  = wr_idx_ff + IDX_W'(1);
         end
         STATE_IDLE: begin
            // Page zero, or the page to free, is read while the request is taken.
            if (req_action == ACT_FREE) begin
               mem_req.raddr = free_page[IDX_W-1:0];
            end else begin
               mem_req.raddr = '0;
            end
            if (accept) begin
               eidx_in = '0;
               run_in  = '0;
               len_in  = req_run_length;
               page_in = free_page[IDX_W-1:0];
               if (req_action == ACT_ALLOC) begin
                  if (len_bad) begin
                     rsp_valid_in   = 1'b1;
                     rsp_status_in  = ST_NOSPACE;
                     rsp_address_in = '0;
                  end
               end else if (free_bad) begin
                  rsp_valid_in   = 1'b1;
                  rsp_status_in  = ST_IGNORED;
                  rsp_address_in = '0;
               end
            end
         end
         STATE_SCAN: begin
            // The read data belongs to page eidx; the next page is read meanwhile.
            eidx_in = eidx_ff + IDX_W'(1);
            run_in  = taken ? '0 : run_inc;
            if (found) begin
               start_in  = run_start[IDX_W-1:0];
               end_in    = eidx_ff;
               wr_idx_in = run_start[IDX_W-1:0];
            end else if (scan_end) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = ST_NOSPACE;
               rsp_address_in = '0;
            end
         end
         STATE_MARK: begin
            mem_req.we    = 1'b1;
            mem_req.wdata = mark_end ? (FLAG_TAKEN | FLAG_LAST) : FLAG_TAKEN;
            wr_idx_in     = wr_idx_ff + IDX_W'(1);
            if (mark_end) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = ST_DONE;
               rsp_address_in = heap_base + (ADDR_W'(start_ff) << PAGE_SHIFT);
            end
         end
         STATE_WALK: begin
            // Clear this page while the following one is read.
            mem_req.raddr = page_ff + IDX_W'(1);
            mem_req.waddr = page_ff;
            mem_req.we    = taken;
            page_in       = page_ff + IDX_W'(1);
            if (walk_end) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = ST_DONE;
               rsp_address_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_CLEAR;
         wr_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_idx_ff    <= wr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      eidx_ff        <= eidx_in;
      run_ff         <= run_in;
      len_ff         <= len_in;
      start_ff       <= start_in;
      end_ff         <= end_in;
      page_ff        <= page_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_address_ff <= rsp_address_in;
   end

   assign busy        = state_ff != STATE_IDLE;
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.status  = rsp_status_ff;
   assign rsp.address = rsp_address_ff;

   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(accept || state_ff == STATE_SCAN
                             || state_ff == STATE_MARK || state_ff == STATE_WALK))
      else $error("result strobe without a request in progress");

   a_scan_read_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff == STATE_SCAN) |-> !mem_req.we)
      else $error("page table written during the scan");

   a_mark_in_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == STATE_MARK) |-> (wr_idx_ff >= start_ff && wr_idx_ff <= end_ff))
      else $error("marking outside the found run");

   a_clear_complete: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff == STATE_CLEAR) && state_ff == STATE_IDLE)
      |-> ($past(wr_idx_ff) == IDX_W'(TABLE_PAGES - 1)))
      else $error("clearing pass ended early");

endmodule
`default_nettype wire

### sv/contiguous_page_allocator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Contiguous page allocator
// First-fit allocator of page runs over a table of per-page flags.
// ----------------------------------------------------------------------------
// After reset the block clears every entry of its page table with busy high;
// register writes are taken meanwhile. A request is transferred when start is
// high and busy is low, and exactly one result follows as a one-cycle strobe
// on rsp_valid, which the receiver must take as it comes. The page table is a
// single memory read one entry per cycle: a rejected request answers the
// cycle after it is taken. A granted allocate answers once its scan reaches
// the last page of the run found and the run has been marked, and an allocate
// that finds no run answers once the whole managed pool has been scanned.
// A free answers once it has visited its pages: the pages it clears, plus
// the free page that stops it if it meets one.
// ----------------------------------------------------------------------------
module contiguous_page_allocator_unit
   import cpa_pkg::*;
(
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      start,
   output logic                     busy,
   input  wire                      req_action,
   input  wire  [LEN_W-1:0]         req_run_length,
   input  wire  [ADDR_W-1:0]        req_block_address,
   output logic                     rsp_valid,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [ADDR_W-1:0]        rsp_address,
   input  wire                      csr_write_enable,
   input  wire                      csr_index,
   input  wire  [CSR_W-1:0]         csr_write_data
);

   logic [ADDR_W-1:0] heap_base_ff, heap_base_in;
   logic [LEN_W-1:0]  pages_in_use_ff, pages_in_use_in;
   logic [CNT_W-1:0]  page_count;
   mem_req_type       mem_req;
   logic [FLAG_W-1:0] rd_data;
   rsp_type           rsp;

   always_comb begin
      heap_base_in    = heap_base_ff;
      pages_in_use_in = pages_in_use_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_HEAP_BASE:    heap_base_in    = csr_write_data[ADDR_W-1:0];
            CSR_PAGES_IN_USE: pages_in_use_in = csr_write_data[LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff    <= '0;
         pages_in_use_ff <= PAGES_RESET;
      end else begin
         heap_base_ff    <= heap_base_in;
         pages_in_use_ff <= pages_in_use_in;
      end
   end

   // The managed count never exceeds the table depth.
   assign page_count = (32'(pages_in_use_ff) > 32'(TABLE_PAGES))
                       ? CNT_W'(TABLE_PAGES) : CNT_W'(pages_in_use_ff);

   cpa_page_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   cpa_engine u_engine (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_run_length    (req_run_length),
      .req_block_address (req_block_address),
      .heap_base         (heap_base_ff),
      .page_count        (page_count),
      .mem_req           (mem_req),
      .rd_data           (rd_data),
      .rsp               (rsp)
   );

   assign rsp_valid   = rsp.valid;
   assign rsp_status  = rsp.status;
   assign rsp_address = rsp.address;

endmodule
`default_nettype wire

### sim/page_reply_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page allocator reply checker
// Watches the request, reply and register ports of the page allocator. Keeps
// its own copy of the page table and of the pool registers, works out the
// reply that each accepted request should produce, and compares every reply
// strobe against the oldest reply still owed.
// ----------------------------------------------------------------------------
module page_reply_checker
   import cpa_pkg::*;
(
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   input  wire                 busy,
   input  wire                 req_action,
   input  wire [LEN_W-1:0]     req_run_length,
   input  wire [ADDR_W-1:0]    req_block_address,
   input  wire                 rsp_valid,
   input  wire [STATUS_W-1:0]  rsp_status,
   input  wire [ADDR_W-1:0]    rsp_address,
   input  wire                 csr_write_enable,
   input  wire                 csr_index,
   input  wire [CSR_W-1:0]     csr_write_data,
   output int                  bad_replies,
   output int                  replies_owed
);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   address;
   } page_reply_type;

   page_reply_type    replies_due[$];
   logic [FLAG_W-1:0] page_table [TABLE_PAGES];
   logic [ADDR_W-1:0] pool_base;
   logic [LEN_W-1:0]  pool_pages;
   int                fault_count;

   // The register may hold more pages than the table has.
   function automatic int managed_count();
      return (pool_pages > TABLE_PAGES) ? TABLE_PAGES : int'(pool_pages);
   endfunction

   function automatic page_reply_type grant_run(input logic [LEN_W-1:0] want);
      page_reply_type r;
      int             n;
      int             run;
      int             first;
      bit             found;
      r.status  = ST_NOSPACE;
      r.address = '0;
      n         = managed_count();
      run       = 0;
      found     = 1'b0;
      if (want != 0 && want <= n) begin
         for (int i = 0; i < n && !found; i++) begin
            if ((page_table[i] & FLAG_TAKEN) != FLAG_FREE) begin
               run = 0;
            end else begin
               run++;
               if (run == want) begin
                  first = i + 1 - run;
                  for (int k = first; k <= i; k++) begin
                     page_table[k] = page_table[k] | FLAG_TAKEN;
                  end
                  page_table[i] = page_table[i] | FLAG_LAST;
                  r.status  = ST_DONE;
                  // The sum wraps at 32 bits, as the block's adder does.
                  r.address = pool_base + ADDR_W'(first * PAGE_BYTES);
                  found     = 1'b1;
               end
            end
         end
      end
      return r;
   endfunction

   function automatic page_reply_type release_block(input logic [ADDR_W-1:0] addr);
      page_reply_type    r;
      int                n;
      int                idx;
      logic [ADDR_W-1:0] offset;
      logic [ADDR_W-1:0] page;
      bit                stop;
      r.address = '0;
      n         = managed_count();
      if (addr == '0 || addr < pool_base) begin
         r.status = ST_IGNORED;
      end else begin
         offset = addr - pool_base;
         page   = offset / PAGE_BYTES;
         if (page >= n) begin
            r.status = ST_IGNORED;
         end else begin
            r.status = ST_DONE;
            idx      = int'(page);
            stop     = 1'b0;
            // The walk ends on the page marked last, on a free page, or at the
            // end of the managed pool, whichever comes first.
            while (idx < n && !stop && (page_table[idx] & FLAG_TAKEN) != FLAG_FREE) begin
               stop            = (page_table[idx] & FLAG_LAST) != FLAG_FREE;
               page_table[idx] = FLAG_FREE;
               idx++;
            end
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      page_reply_type due;
      if (reset) begin
         for (int i = 0; i < TABLE_PAGES; i++) begin
            page_table[i] = FLAG_FREE;
         end
         pool_base   = '0;
         pool_pages  = PAGES_RESET;
         fault_count = 0;
         replies_due.delete();
      end else begin
         if (rsp_valid) begin
            if (replies_due.size() == 0) begin
               if (fault_count < 10) begin
                  $display("%t: reply with none owed: status %0d address %h",
                           $realtime, rsp_status, rsp_address);
               end
               fault_count++;
            end else begin
               due = replies_due.pop_front();
               if (rsp_status !== due.status || rsp_address !== due.address) begin
                  if (fault_count < 10) begin
                     $display({"%t: reply mismatch: expected status %0d address %h, ",
                               "got status %0d address %h"},
                              $realtime, due.status, due.address,
                              rsp_status, rsp_address);
                  end
                  fault_count++;
               end
            end
         end
         if (csr_write_enable) begin
            if (csr_index == CSR_HEAP_BASE) begin
               pool_base = csr_write_data[ADDR_W-1:0];
            end else begin
               pool_pages = csr_write_data[LEN_W-1:0];
            end
         end
         if (start && !busy) begin
            if (req_action == ACT_FREE) begin
               replies_due.push_back(release_block(req_block_address));
            end else begin
               replies_due.push_back(grant_run(req_run_length));
            end
         end
      end
      bad_replies  <= fault_count;
      replies_owed <= replies_due.size();
   end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contiguous page allocator testbench
// Drives allocate and free requests into the allocator, first a handful of
// directed corner cases and then random traffic over several pool settings
// and sender idle rates. A separate checker predicts and compares replies;
// this module only makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb;
   import cpa_pkg::*;

   localparam int PHASE_ITEMS  = 280;
   localparam int STALL_LIMIT  = 20000;
   localparam int TAIL_CYCLES  = 2100;
   localparam int LIVE_CEILING = 12;

   logic              clock;
   logic              reset             = 1'b1;
   logic              start             = 1'b0;
   logic              req_action        = ACT_ALLOC;
   logic [LEN_W-1:0]  req_run_length    = '0;
   logic [ADDR_W-1:0] req_block_address = '0;
   logic              csr_write_enable  = 1'b0;
   logic              csr_index         = CSR_HEAP_BASE;
   logic [CSR_W-1:0]  csr_write_data    = '0;
   logic              busy;
   logic              rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [ADDR_W-1:0] rsp_address;

   int                bad_replies;
   int                replies_owed;
   int                quiet_cycles = 0;
   int                sender_idle_pct = 0;
   logic [ADDR_W-1:0] cur_base  = '0;
   logic [LEN_W-1:0]  cur_pages = PAGES_RESET;
   logic              sent_kinds[$];
   logic [ADDR_W-1:0] live_blocks[$];

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   contiguous_page_allocator_unit dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_run_length    (req_run_length),
      .req_block_address (req_block_address),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_address       (rsp_address),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   page_reply_checker reply_check (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_run_length    (req_run_length),
      .req_block_address (req_block_address),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_address       (rsp_address),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .bad_replies       (bad_replies),
      .replies_owed      (replies_owed)
   );

   // Granted block addresses are remembered so that most frees are well formed.
   always @(posedge clock) begin
      if (reset) begin
         sent_kinds.delete();
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid && sent_kinds.size() > 0) begin
            if (sent_kinds.pop_front() == ACT_ALLOC && rsp_status == ST_DONE) begin
               live_blocks.push_back(rsp_address);
            end
         end
         if (start && !busy) begin
            sent_kinds.push_back(req_action);
         end
         if ((start && !busy) || rsp_valid || csr_write_enable) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin
      wait (quiet_cycles >= STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Holds start high until the request transfer happens; start is left high
   // so that a following request may go out back to back.
   task automatic send_request(input logic act, input logic [LEN_W-1:0] len,
                               input logic [ADDR_W-1:0] addr);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start             <= 1'b1;
      req_action        <= act;
      req_run_length    <= len;
      req_block_address <= addr;
      do @(posedge clock); while (busy);
   endtask

   task automatic settle();
      start <= 1'b0;
      do @(negedge clock); while (replies_owed != 0 || busy);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_pool(input logic [ADDR_W-1:0] base, input logic [LEN_W-1:0] pages);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_HEAP_BASE;
      csr_write_data   <= CSR_W'(base);
      @(posedge clock);
      csr_index        <= CSR_PAGES_IN_USE;
      csr_write_data   <= CSR_W'(pages);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cur_base  = base;
      cur_pages = pages;
   endtask

   task automatic run_phase(input int idle_pct, input logic [ADDR_W-1:0] base,
                            input logic [LEN_W-1:0] pages);
      int                eff;
      int                pick;
      int                slot;
      logic [ADDR_W-1:0] target;
      logic [LEN_W-1:0]  want;
      // Give back what the previous phase still holds before the pool moves.
      settle();
      while (live_blocks.size() > 0) begin
         send_request(ACT_FREE, LEN_W'($urandom()), live_blocks.pop_front());
      end
      settle();
      set_pool(base, pages);
      sender_idle_pct = idle_pct;
      eff = (cur_pages > TABLE_PAGES) ? TABLE_PAGES : int'(cur_pages);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            // Stray frees: null, random, below the base, past the pool, or a
            // page picked blindly inside the pool.
            case ($urandom_range(0, 5))
               0: target = '0;
               1: target = $urandom();
               2: target = cur_base - 1 - $urandom_range(0, 1023);
               3: target = cur_base + ADDR_W'(eff * PAGE_BYTES) + $urandom_range(0, 4095);
               default: target = cur_base + $urandom_range(0, 255)
                                 + ADDR_W'(((eff > 0) ? $urandom_range(0, eff - 1) : 0)
                                           * PAGE_BYTES);
            endcase
            send_request(ACT_FREE, LEN_W'($urandom()), target);
         end else if (live_blocks.size() > 0 &&
                      (pick < 50 || live_blocks.size() >= LIVE_CEILING)) begin
            slot   = $urandom_range(0, live_blocks.size() - 1);
            target = live_blocks[slot];
            live_blocks.delete(slot);
            if ($urandom_range(0, 3) == 0) begin
               target = target + $urandom_range(1, PAGE_BYTES - 1);
            end
            send_request(ACT_FREE, LEN_W'($urandom()), target);
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 78) begin
               want = LEN_W'($urandom_range(1, 8));
            end else if (pick < 88) begin
               want = LEN_W'($urandom_range(1, (eff > 0) ? eff : 1));
            end else if (pick < 92) begin
               want = '0;
            end else if (pick < 96) begin
               want = LEN_W'($urandom_range(eff + 1, 2047));
            end else begin
               want = LEN_W'($urandom());
            end
            send_request(ACT_ALLOC, want, $urandom());
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part, first at the reset settings of the pool.
      sender_idle_pct = 37;
      send_request(ACT_ALLOC, 11'd1, $urandom());
      send_request(ACT_FREE, LEN_W'($urandom()), 32'h0000_0000);
      send_request(ACT_ALLOC, 11'd0, $urandom());
      send_request(ACT_ALLOC, 11'd1025, $urandom());
      send_request(ACT_ALLOC, 11'd2047, $urandom());
      send_request(ACT_ALLOC, 11'd1024, $urandom());
      send_request(ACT_FREE, LEN_W'($urandom()), 32'h0000_0100);
      send_request(ACT_FREE, LEN_W'($urandom()), 32'hFFFF_FFFF);

      settle();
      set_pool(32'h0000_1000, 11'd4);
      send_request(ACT_FREE, LEN_W'($urandom()), 32'h0000_0FFF);
      send_request(ACT_ALLOC, 11'd3, $urandom());
      send_request(ACT_FREE, LEN_W'($urandom()), 32'h0000_1234);
      send_request(ACT_FREE, LEN_W'($urandom()), 32'h0000_1400);
      send_request(ACT_ALLOC, 11'd4, $urandom());

      // A block reaching past the pool once it shrinks: the free walk must stop
      // at the pool end and the pages beyond keep their flags.
      settle();
      set_pool(32'h0000_1000, 11'd8);
      send_request(ACT_ALLOC, 11'd6, $urandom());
      settle();
      set_pool(32'h0000_1000, 11'd5);
      send_request(ACT_FREE, LEN_W'($urandom()), 32'h0000_1200);

      settle();
      set_pool(32'h0000_1000, 11'd0);
      send_request(ACT_ALLOC, 11'd1, $urandom());
      send_request(ACT_FREE, LEN_W'($urandom()), 32'h0000_1000);

      // Granted addresses wrap past the top of the address space here.
      settle();
      set_pool(32'hFFFF_FF00, 11'd1024);
      send_request(ACT_ALLOC, 11'd1, $urandom());
      send_request(ACT_ALLOC, 11'd2, $urandom());
      send_request(ACT_ALLOC, 11'd3, $urandom());

      settle();
      set_pool(32'hFFFF_FFFF, 11'd2047);
      send_request(ACT_FREE, LEN_W'($urandom()), 32'hFFFF_FFFF);
      send_request(ACT_FREE, LEN_W'($urandom()), 32'h7FFF_FFFF);

      run_phase(37, 32'h0001_0000, 11'd64);
      run_phase(37, 32'hFFFF_C000, 11'd1024);
      run_phase(76, 32'h0000_0000, 11'd1);
      run_phase(76, 32'h8000_0000, 11'd300);
      run_phase(0, 32'h1234_5600, 11'd1024);
      run_phase(0, 32'h0000_0100, 11'd16);

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (bad_replies == 0 && replies_owed == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
